// ----- hdl/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the wall segment projection pipeline.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 8;
    localparam int DIFF_W    = COORD_W + 1;       // endpoint minus camera
    localparam int PROD_W    = DIFF_W + COORD_W;  // diff times trig value
    localparam int SUM_W     = PROD_W + 1;        // lateral and depth
    localparam int DEP_W     = SUM_W - 1;         // positive depth magnitude
    localparam int LAT_W     = SUM_W - 1;         // lateral magnitude
    localparam int NUM_SX_W  = LAT_W + COORD_W;   // |lateral| * focal
    localparam int HH_SHIFT  = 22;
    localparam int NUM_HH_W  = COORD_W + HH_SHIFT; // focal << 22
    localparam int SX_QBITS  = 17;                // quotient bits for screen x
    localparam int HH_QBITS  = 16;                // quotient bits for half height
    localparam int REM_SX_W  = DEP_W + SX_QBITS;
    localparam int REM_HH_W  = DEP_W + HH_QBITS;
    localparam int LAT_X     = 4;                 // transform stages
    localparam int LAT_D     = SX_QBITS + 1;      // overflow check plus one bit a stage

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_CAM_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAM_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_COS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_SIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL   = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_y;
        logic signed [COORD_W-1:0] dir_cos;
        logic signed [COORD_W-1:0] dir_sin;
        logic [COORD_W-1:0]        focal;
    } t_cfg;

    // one endpoint, ready for division
    typedef struct packed {
        logic                neg;
        logic                ok;
        logic [NUM_SX_W-1:0] num_sx;
        logic [NUM_HH_W-1:0] num_hh;
        logic [DEP_W-1:0]    dep;
    } t_ep_num;

    typedef struct packed {
        logic                      ok;
        logic signed [COORD_W-1:0] sx;
        logic [COORD_W-1:0]        hh;
    } t_ep_res;

endpackage

// ----- hdl/wsp_xform.sv -----
// ----------------------------------------------------------------------------
// wsp_xform
// Camera-space transform of one endpoint and numerator build, four stages.
// ----------------------------------------------------------------------------
module wsp_xform (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  wsp_pkg::t_cfg                       i_cfg,
    input  logic signed [wsp_pkg::COORD_W-1:0]  i_x,
    input  logic signed [wsp_pkg::COORD_W-1:0]  i_y,
    output wsp_pkg::t_ep_num                    o_num
);

    logic signed [wsp_pkg::DIFF_W-1:0] r_dx, r_dy;
    logic signed [wsp_pkg::PROD_W-1:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [wsp_pkg::SUM_W-1:0]  n_lat, n_dep;
    logic                              r_neg, r_ok;
    logic [wsp_pkg::LAT_W-1:0]         r_lat_mag;
    logic [wsp_pkg::DEP_W-1:0]         r_dep;
    wsp_pkg::t_ep_num                  r_num;

    always_comb begin
        n_lat = wsp_pkg::SUM_W'(r_xs) - wsp_pkg::SUM_W'(r_yc);
        n_dep = wsp_pkg::SUM_W'(r_xc) + wsp_pkg::SUM_W'(r_ys);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= wsp_pkg::DIFF_W'(i_x) - wsp_pkg::DIFF_W'(i_cfg.cam_x);
            r_dy <= wsp_pkg::DIFF_W'(i_y) - wsp_pkg::DIFF_W'(i_cfg.cam_y);

            r_xc <= wsp_pkg::PROD_W'(r_dx * i_cfg.dir_cos);
            r_ys <= wsp_pkg::PROD_W'(r_dy * i_cfg.dir_sin);
            r_xs <= wsp_pkg::PROD_W'(r_dx * i_cfg.dir_sin);
            r_yc <= wsp_pkg::PROD_W'(r_dy * i_cfg.dir_cos);

            r_neg     <= n_lat[wsp_pkg::SUM_W-1];
            r_lat_mag <= n_lat[wsp_pkg::SUM_W-1] ? wsp_pkg::LAT_W'(-n_lat)
                                                 : wsp_pkg::LAT_W'(n_lat);
            r_ok      <= !n_dep[wsp_pkg::SUM_W-1] && (n_dep != '0);
            r_dep     <= wsp_pkg::DEP_W'(n_dep);

            r_num.neg    <= r_neg;
            r_num.ok     <= r_ok;
            r_num.num_sx <= wsp_pkg::NUM_SX_W'(r_lat_mag * i_cfg.focal);
            r_num.num_hh <= {i_cfg.focal, {wsp_pkg::HH_SHIFT{1'b0}}};
            r_num.dep    <= r_dep;
        end
    end

    assign o_num = r_num;

endmodule

// ----- hdl/wsp_div.sv -----
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined restoring divider for screen x and half height, one bit a stage,
// with overflow check up front and saturation on the way out.
// ----------------------------------------------------------------------------
module wsp_div (
    input  logic             i_clk,
    input  logic             i_en,
    input  wsp_pkg::t_ep_num i_num,
    output wsp_pkg::t_ep_res o_res
);

    localparam int NS = wsp_pkg::LAT_D;

    logic [wsp_pkg::REM_SX_W-1:0] r_rs  [NS];
    logic [wsp_pkg::REM_HH_W-1:0] r_rh  [NS];
    logic [wsp_pkg::SX_QBITS-1:0] r_qs  [NS];
    logic [wsp_pkg::HH_QBITS-1:0] r_qh  [NS];
    logic [wsp_pkg::DEP_W-1:0]    r_dep [NS];
    logic                         r_neg [NS];
    logic                         r_ok  [NS];
    logic                         r_ovs [NS];
    logic                         r_ovh [NS];

    // stage 0: overflow test, load remainders
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovs[0] <= wsp_pkg::REM_SX_W'(i_num.num_sx) >=
                        (wsp_pkg::REM_SX_W'(i_num.dep) << wsp_pkg::SX_QBITS);
            r_ovh[0] <= wsp_pkg::REM_HH_W'(i_num.num_hh) >=
                        (wsp_pkg::REM_HH_W'(i_num.dep) << wsp_pkg::HH_QBITS);
            r_rs[0]  <= wsp_pkg::REM_SX_W'(i_num.num_sx);
            r_rh[0]  <= wsp_pkg::REM_HH_W'(i_num.num_hh);
            r_qs[0]  <= '0;
            r_qh[0]  <= '0;
            r_dep[0] <= i_num.dep;
            r_neg[0] <= i_num.neg;
            r_ok[0]  <= i_num.ok;
        end
    end

    for (genvar j = 1; j < NS; j++) begin : g_stage
        localparam int K = wsp_pkg::SX_QBITS - j;
        logic [wsp_pkg::REM_SX_W-1:0] d_sx;
        logic                         take_sx;

        always_comb begin
            d_sx    = wsp_pkg::REM_SX_W'(r_dep[j-1]) << K;
            take_sx = r_rs[j-1] >= d_sx;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rs[j]  <= take_sx ? r_rs[j-1] - d_sx : r_rs[j-1];
                r_qs[j]  <= {r_qs[j-1][wsp_pkg::SX_QBITS-2:0], take_sx};
                r_dep[j] <= r_dep[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ok[j]  <= r_ok[j-1];
                r_ovs[j] <= r_ovs[j-1];
                r_ovh[j] <= r_ovh[j-1];
            end
        end

        if (K < wsp_pkg::HH_QBITS) begin : g_hh
            logic [wsp_pkg::REM_HH_W-1:0] d_hh;
            logic                         take_hh;
            always_comb begin
                d_hh    = wsp_pkg::REM_HH_W'(r_dep[j-1]) << K;
                take_hh = r_rh[j-1] >= d_hh;
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rh[j] <= take_hh ? r_rh[j-1] - d_hh : r_rh[j-1];
                    r_qh[j] <= {r_qh[j-1][wsp_pkg::HH_QBITS-2:0], take_hh};
                end
            end
        end else begin : g_hh_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rh[j] <= r_rh[j-1];
                    r_qh[j] <= r_qh[j-1];
                end
            end
        end
    end

    // saturate: magnitude of 2^15 and up clips to the rail on either sign
    logic                          sx_big;
    logic [wsp_pkg::COORD_W-1:0]   mag16;

    always_comb begin
        sx_big = r_ovs[NS-1] || r_qs[NS-1][wsp_pkg::SX_QBITS-1];
        mag16  = r_qs[NS-1][wsp_pkg::COORD_W-1:0];
        o_res.ok = r_ok[NS-1];
        if (!r_ok[NS-1]) begin
            o_res.sx = '0;
            o_res.hh = '0;
        end else begin
            if (sx_big || mag16[wsp_pkg::COORD_W-1]) begin
                o_res.sx = r_neg[NS-1] ? 16'sh8000 : 16'sh7fff;
            end else begin
                o_res.sx = r_neg[NS-1] ? -$signed(mag16) : $signed(mag16);
            end
            o_res.hh = r_ovh[NS-1] ? '1 : r_qh[NS-1];
        end
    end

endmodule

// ----- hdl/wall_segment_perspective_project_unit.sv -----
// ----------------------------------------------------------------------------
// wall_segment_perspective_project_unit
// Projects one wall segment's endpoints to screen x and half height.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  segment  | in        | i_valid / o_stall    | start/end x,y, rgb
//  result   | out       | o_valid / i_stall    | screen x, half height, rgb, flag
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_addr, i_cfg_data
//
//  One segment per cycle unless stalled. 4 transform stages, an overflow
//  stage and 17 divider stages (one quotient bit each), then the output
//  register. Synchronous active-low reset clears valids, loads default config.
//  A stalled result freezes the whole pipeline; bubbles still fill it.
// ----------------------------------------------------------------------------
module wall_segment_perspective_project_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [wsp_pkg::COORD_W-1:0]      i_start_x,
    input  logic signed [wsp_pkg::COORD_W-1:0]      i_start_y,
    input  logic signed [wsp_pkg::COORD_W-1:0]      i_end_x,
    input  logic signed [wsp_pkg::COORD_W-1:0]      i_end_y,
    input  logic [wsp_pkg::COLOR_W-1:0]             i_red_in,
    input  logic [wsp_pkg::COLOR_W-1:0]             i_green_in,
    input  logic [wsp_pkg::COLOR_W-1:0]             i_blue_in,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [wsp_pkg::COORD_W-1:0]      o_screen_x_start,
    output logic [wsp_pkg::COORD_W-1:0]             o_half_height_start,
    output logic signed [wsp_pkg::COORD_W-1:0]      o_screen_x_end,
    output logic [wsp_pkg::COORD_W-1:0]             o_half_height_end,
    output logic [wsp_pkg::COLOR_W-1:0]             o_red_out,
    output logic [wsp_pkg::COLOR_W-1:0]             o_green_out,
    output logic [wsp_pkg::COLOR_W-1:0]             o_blue_out,
    output logic                                    o_depth_invalid,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [wsp_pkg::CFG_ADDR_W-1:0]          i_cfg_addr,
    input  logic [wsp_pkg::COORD_W-1:0]             i_cfg_data
);

    localparam int LAT = wsp_pkg::LAT_X + wsp_pkg::LAT_D;

    wsp_pkg::t_cfg    r_cfg;
    wsp_pkg::t_ep_num num_s, num_e;
    wsp_pkg::t_ep_res res_s, res_e;
    logic             en;
    logic             r_out_valid;

    logic                        r_sb_valid [LAT];
    logic [3*wsp_pkg::COLOR_W-1:0] r_sb_rgb [LAT];

    assign en          = !r_out_valid || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_x   <= '0;
            r_cfg.cam_y   <= '0;
            r_cfg.dir_cos <= 16'sd16384;
            r_cfg.dir_sin <= '0;
            r_cfg.focal   <= 16'd4096;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                wsp_pkg::REG_CAM_X:   r_cfg.cam_x   <= $signed(i_cfg_data);
                wsp_pkg::REG_CAM_Y:   r_cfg.cam_y   <= $signed(i_cfg_data);
                wsp_pkg::REG_DIR_COS: r_cfg.dir_cos <= $signed(i_cfg_data);
                wsp_pkg::REG_DIR_SIN: r_cfg.dir_sin <= $signed(i_cfg_data);
                wsp_pkg::REG_FOCAL:   r_cfg.focal   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wsp_xform u_xf_s (.i_clk, .i_en(en), .i_cfg(r_cfg),
                      .i_x(i_start_x), .i_y(i_start_y), .o_num(num_s));
    wsp_xform u_xf_e (.i_clk, .i_en(en), .i_cfg(r_cfg),
                      .i_x(i_end_x), .i_y(i_end_y), .o_num(num_e));
    wsp_div   u_dv_s (.i_clk, .i_en(en), .i_num(num_s), .o_res(res_s));
    wsp_div   u_dv_e (.i_clk, .i_en(en), .i_num(num_e), .o_res(res_e));

    // valid and colour ride alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_sb_valid[s] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sb_valid[0] <= i_valid;
            for (int s = 1; s < LAT; s++) r_sb_valid[s] <= r_sb_valid[s-1];
            r_out_valid <= r_sb_valid[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_rgb[0] <= {i_red_in, i_green_in, i_blue_in};
            for (int s = 1; s < LAT; s++) r_sb_rgb[s] <= r_sb_rgb[s-1];
            o_screen_x_start    <= res_s.sx;
            o_half_height_start <= res_s.hh;
            o_screen_x_end      <= res_e.sx;
            o_half_height_end   <= res_e.hh;
            {o_red_out, o_green_out, o_blue_out} <= r_sb_rgb[LAT-1];
            o_depth_invalid     <= !(res_s.ok && res_e.ok);
        end
    end

`ifndef SYNTHESIS
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall) else $error("stall raised with empty output");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_sb_valid[0]) else $error("accepted request lost");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(r_sb_valid[LAT-1]) && $stable(r_out_valid)))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams wall segments through the projection unit under random idling and
// backpressure, predicts screen x, half height and the depth flag for each
// request, and checks every result in order. Camera setup changes between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic signed [15:0] sx0, sy0, ex0, ey0;
        logic [7:0]         r, g, b;
    } t_seg;

    typedef struct packed {
        logic signed [15:0] sxs;
        logic [15:0]        hhs;
        logic signed [15:0] sxe;
        logic [15:0]        hhe;
        logic [7:0]         r, g, b;
        logic               bad;
    } t_proj;

    localparam int HOLD_CYCLES = 80;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, o_stall, o_valid, i_stall = 0;
    logic signed [15:0] i_start_x = 0, i_start_y = 0, i_end_x = 0, i_end_y = 0;
    logic [7:0] i_red_in = 0, i_green_in = 0, i_blue_in = 0;
    logic signed [15:0] o_screen_x_start, o_screen_x_end;
    logic [15:0] o_half_height_start, o_half_height_end;
    logic [7:0] o_red_out, o_green_out, o_blue_out;
    logic o_depth_invalid;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [wsp_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_data = 0;

    wall_segment_perspective_project_unit u_dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // camera model
    longint cam_x = 0, cam_y = 0, cos_v = 16384, sin_v = 0, focal = 4096;
    t_seg  seg_q[$];
    t_proj proj_q[$];
    int    errors = 0;
    bit    hold_off = 0;
    int    hold_cnt = 0;
    int    gap_left = 0, burst_left = 0;

    function automatic bit project_point(input longint x, input longint y,
                                         output logic [15:0] sx,
                                         output logic [15:0] hh);
        longint dx, dy, lat, dep, q, h;
        bit ok;
        dx = x - cam_x;
        dy = y - cam_y;
        lat = dx * sin_v - dy * cos_v;
        dep = dx * cos_v + dy * sin_v;
        ok = dep > 0;
        sx = 0;
        hh = 0;
        if (ok) begin
            q = (lat * focal) / dep;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            h = (focal <<< 22) / dep;
            if (h > 65535) h = 65535;
            sx = q[15:0];
            hh = h[15:0];
        end
        return ok;
    endfunction

    function automatic t_proj project_segment(t_seg s);
        t_proj p;
        bit oks, oke;
        oks = project_point(s.sx0, s.sy0, p.sxs, p.hhs);
        oke = project_point(s.ex0, s.ey0, p.sxe, p.hhe);
        p.r = s.r;
        p.g = s.g;
        p.b = s.b;
        p.bad = !(oks && oke);
        return p;
    endfunction

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                proj_q.push_back(project_segment(seg_q.pop_front()));
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 0;
                end else if (seg_q.size() > 0) begin
                    i_valid <= 1;
                    {i_start_x, i_start_y, i_end_x, i_end_y, i_red_in, i_green_in, i_blue_in}
                        <= seg_q[0];
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold once requested
    always @(posedge i_clk) begin
        if (hold_off && hold_cnt < HOLD_CYCLES) begin
            i_stall <= 1;
            hold_cnt <= hold_cnt + 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall <= $urandom_range(0, 1);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_proj e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (proj_q.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                e = proj_q.pop_front();
                if (o_screen_x_start !== e.sxs) begin
                    $error("screen_x_start exp %0d got %0d", e.sxs, o_screen_x_start);
                    errors++;
                end
                if (o_half_height_start !== e.hhs) begin
                    $error("half_height_start exp %0d got %0d", e.hhs, o_half_height_start);
                    errors++;
                end
                if (o_screen_x_end !== e.sxe) begin
                    $error("screen_x_end exp %0d got %0d", e.sxe, o_screen_x_end);
                    errors++;
                end
                if (o_half_height_end !== e.hhe) begin
                    $error("half_height_end exp %0d got %0d", e.hhe, o_half_height_end);
                    errors++;
                end
                if (o_red_out !== e.r) begin
                    $error("red_out exp %0d got %0d", e.r, o_red_out);
                    errors++;
                end
                if (o_green_out !== e.g) begin
                    $error("green_out exp %0d got %0d", e.g, o_green_out);
                    errors++;
                end
                if (o_blue_out !== e.b) begin
                    $error("blue_out exp %0d got %0d", e.b, o_blue_out);
                    errors++;
                end
                if (o_depth_invalid !== e.bad) begin
                    $error("depth_invalid exp %0d got %0d", e.bad, o_depth_invalid);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [wsp_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            wsp_pkg::REG_CAM_X:   cam_x = $signed(val);
            wsp_pkg::REG_CAM_Y:   cam_y = $signed(val);
            wsp_pkg::REG_DIR_COS: cos_v = $signed(val);
            wsp_pkg::REG_DIR_SIN: sin_v = $signed(val);
            wsp_pkg::REG_FOCAL:   focal = val;
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [15:0] cx, cy, c, s, f);
        write_reg(wsp_pkg::REG_CAM_X, cx);
        write_reg(wsp_pkg::REG_CAM_Y, cy);
        write_reg(wsp_pkg::REG_DIR_COS, c);
        write_reg(wsp_pkg::REG_DIR_SIN, s);
        write_reg(wsp_pkg::REG_FOCAL, f);
    endtask

    function automatic t_seg rand_seg(bit near);
        t_seg s;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        s = raw[$bits(t_seg)-1:0];
        if (near) begin
            // keep endpoints near the camera so quotients stay in range
            s.sx0 = 16'(cam_x + $signed(16'($urandom_range(0, 8191)) - 16'sd4096));
            s.sy0 = 16'(cam_y + $signed(16'($urandom_range(0, 8191)) - 16'sd4096));
            s.ex0 = 16'(cam_x + $signed(16'($urandom_range(0, 8191)) - 16'sd4096));
            s.ey0 = 16'(cam_y + $signed(16'($urandom_range(0, 8191)) - 16'sd4096));
        end
        return s;
    endfunction

    task automatic wait_drained();
        while (seg_q.size() > 0 || i_valid || proj_q.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        repeat (n) seg_q.push_back(rand_seg($urandom_range(0, 3) != 0));
        wait_drained();
    endtask

    initial begin
        t_seg s;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset camera looks along +x
        s = '{16'sh0100, 16'sh0000, 16'sh0200, 16'sh0100, 8'd0, 8'd255, 8'd128};
        seg_q.push_back(s);
        s = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 8'd255, 8'd0, 8'd1};
        seg_q.push_back(s);
        s = '{16'sh0000, 16'sh0000, 16'sh0001, 16'sh7fff, 8'hAA, 8'h55, 8'hFF};
        seg_q.push_back(s);
        s = '{16'sh0001, 16'sh8000, 16'sh0001, 16'sh0000, 8'h55, 8'hAA, 8'h00};
        seg_q.push_back(s);
        s = '{16'shff00, 16'sh0000, 16'sh0100, 16'sh0000, 8'd7, 8'd8, 8'd9};
        seg_q.push_back(s);
        wait_drained();

        set_camera(16'h8000, 16'h7fff, 16'h4000, 16'h0000, 16'hffff);
        s = '{16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh7fff, 8'd1, 8'd2, 8'd3};
        seg_q.push_back(s);
        run_random(40);

        // degenerate direction
        set_camera(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
        run_random(10);

        set_camera(16'h7fff, 16'h8000, 16'hc000, 16'h0000, 16'h0000);
        run_random(30);

        set_camera(16'h0123, 16'hfe00, 16'h2d41, 16'h2d41, 16'h1000);
        // backpressure: hold the receiver while requests pile up
        hold_off = 1;
        repeat (60) seg_q.push_back(rand_seg(1));
        wait (hold_cnt >= HOLD_CYCLES);
        hold_off = 0;
        wait_drained();

        set_camera(16'h0000, 16'h0000, 16'h0000, 16'hc000, 16'h2000);
        run_random(100);
        set_camera(16'($urandom), 16'($urandom), 16'h3b21, 16'h187e, 16'($urandom));
        run_random(150);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
